// ===== src/utf8sv_pkg.sv =====
// Shared types and status codes for the UTF-8 stream validator.
`timescale 1ns / 1ps
package utf8sv_pkg;

  localparam int unsigned CountBitsDefault = 16;
  localparam int unsigned CharCountBits = 16;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_LEAD   = 3'd1;
  localparam logic [2:0] ST_BAD_CONT   = 3'd2;
  localparam logic [2:0] ST_OVERLONG   = 3'd3;
  localparam logic [2:0] ST_NOT_SCALAR = 3'd4;
  localparam logic [2:0] ST_TRUNC      = 3'd5;
  localparam logic [2:0] ST_NUL        = 3'd6;
  localparam logic [2:0] ST_FAILED     = 3'd7;

  localparam logic REG_LF_PRINTABLE = 1'b0;
  localparam logic REG_NUL_IS_ERROR = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [30:0]              code_point;
    logic [2:0]               seq_len;
    logic [2:0]               status;
    logic                     printable;
    logic                     end_of_string;
    logic [CharCountBits-1:0] char_count;
  } out_item_t;

  typedef struct packed {
    logic lf_printable;
    logic nul_is_error;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  expected_len;
    logic [2:0]  bytes_seen;
    logic [30:0] accum_value;
    logic        failed_flag;
  } seq_state_t;

endpackage

// ===== src/utf8sv_regs.sv =====
// APB-style configuration registers of the UTF-8 stream validator.
`timescale 1ns / 1ps
module utf8sv_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output utf8sv_pkg::cfg_t  cfg_o
);
  import utf8sv_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_LF_PRINTABLE: cfg_d.lf_printable = pwdata[0];
        REG_NUL_IS_ERROR: cfg_d.nul_is_error = pwdata[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LF_PRINTABLE: prdata = {31'd0, cfg_q.lf_printable};
      REG_NUL_IS_ERROR: prdata = {31'd0, cfg_q.nul_is_error};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{lf_printable: 1'b1, nul_is_error: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/utf8sv_decode.sv =====
// Per-byte decode logic: next sequence state, result and count update.
`timescale 1ns / 1ps
module utf8sv_decode #(
  parameter int unsigned COUNT_BITS = utf8sv_pkg::CountBitsDefault
) (
  input  utf8sv_pkg::in_item_t   item_i,
  input  utf8sv_pkg::cfg_t       cfg_i,
  input  utf8sv_pkg::seq_state_t seq_i,
  input  logic [COUNT_BITS-1:0]  count_i,
  output utf8sv_pkg::seq_state_t seq_o,
  output logic [COUNT_BITS-1:0]  count_o,
  output logic                   emit_o,
  output utf8sv_pkg::out_item_t  result_o
);
  import utf8sv_pkg::*;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] res;
    case (b) inside
      8'b0???????: res = 3'd1;
      8'b110?????: res = 3'd2;
      8'b1110????: res = 3'd3;
      8'b11110???: res = 3'd4;
      8'b111110??: res = 3'd5;
      8'b1111110?: res = 3'd6;
      default:     res = 3'd0;
    endcase
    return res;
  endfunction

  function automatic logic [2:0] shortest_len(input logic [30:0] v);
    logic [2:0] res;
    if (v < 31'h80) res = 3'd1;
    else if (v < 31'h800) res = 3'd2;
    else if (v < 31'h10000) res = 3'd3;
    else if (v < 31'h200000) res = 3'd4;
    else if (v < 31'h4000000) res = 3'd5;
    else res = 3'd6;
    return res;
  endfunction

  function automatic logic scalar_ok(input logic [30:0] v);
    logic ok;
    ok = 1'b1;
    if (v >= 31'h110000) ok = 1'b0;
    if (v[30:11] == 20'h0001B) ok = 1'b0;
    if (v >= 31'hFDD0 && v <= 31'hFDEF) ok = 1'b0;
    if (&v[15:1]) ok = 1'b0;
    return ok;
  endfunction

  function automatic logic printable_of(input logic [30:0] v, input logic allow_nl);
    logic res;
    res = 1'b1;
    if (v < 31'h20 && v != 31'h09 && v != 31'h0A) res = 1'b0;
    if (v >= 31'h7F && v <= 31'h9F) res = 1'b0;
    if (v == 31'h0A && !allow_nl) res = 1'b0;
    return res;
  endfunction

  logic [7:0]            b;
  logic [2:0]            n;
  logic [30:0]           acc_next;
  logic [2:0]            seen_next;
  logic [30:0]           cp;
  logic [2:0]            len;
  logic [2:0]            st;
  logic                  pr;
  logic                  emit;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [32:0]           cnt_ext;

  assign b         = item_i.data_byte;
  assign n         = lead_len(b);
  assign acc_next  = {seq_i.accum_value[24:0], b[5:0]};
  assign seen_next = seq_i.bytes_seen + 3'd1;

  always_comb begin
    seq_o    = seq_i;
    emit     = 1'b0;
    cp       = 31'd0;
    len      = 3'd0;
    st       = ST_OK;
    pr       = 1'b0;
    cnt_next = count_i;

    if (seq_i.failed_flag) begin
      if (item_i.last_byte) begin
        emit = 1'b1;
        st   = ST_FAILED;
      end
    end else if (seq_i.expected_len == 3'd0) begin
      if (b == 8'd0 && cfg_i.nul_is_error) begin
        emit = 1'b1;
        st   = ST_NUL;
        len  = 3'd1;
      end else if (n == 3'd0) begin
        emit = 1'b1;
        st   = ST_BAD_LEAD;
      end else if (n == 3'd1) begin
        emit = 1'b1;
        cp   = {23'd0, b};
        len  = 3'd1;
        pr   = printable_of({23'd0, b}, cfg_i.lf_printable);
      end else begin
        seq_o.expected_len = n;
        seq_o.bytes_seen   = 3'd1;
        seq_o.accum_value  = {23'd0, b & (8'h7F >> n)};
        if (item_i.last_byte) begin
          emit = 1'b1;
          st   = ST_TRUNC;
          len  = n;
        end
      end
    end else begin
      len = seq_i.expected_len;
      if (b[7:6] != 2'b10) begin
        emit = 1'b1;
        st   = ST_BAD_CONT;
      end else begin
        seq_o.accum_value = acc_next;
        seq_o.bytes_seen  = seen_next;
        if (seen_next >= seq_i.expected_len) begin
          emit = 1'b1;
          if (shortest_len(acc_next) != seq_i.expected_len) begin
            st = ST_OVERLONG;
          end else if (!scalar_ok(acc_next)) begin
            st = ST_NOT_SCALAR;
          end else begin
            cp = acc_next;
            pr = printable_of(acc_next, cfg_i.lf_printable);
          end
        end else if (item_i.last_byte) begin
          emit = 1'b1;
          st   = ST_TRUNC;
        end
      end
      if (emit) begin
        seq_o.expected_len = 3'd0;
        seq_o.bytes_seen   = 3'd0;
        seq_o.accum_value  = 31'd0;
      end
    end

    if (emit) begin
      if (st == ST_OK) begin
        if (count_i != {COUNT_BITS{1'b1}}) begin
          cnt_next = count_i + COUNT_BITS'(1);
        end
      end else begin
        seq_o.failed_flag = 1'b1;
        cp = 31'd0;
        pr = 1'b0;
        if (st == ST_FAILED || st == ST_BAD_LEAD) begin
          len = 3'd0;
        end
      end
    end

    if (item_i.last_byte) begin
      seq_o = '0;
    end
  end

  assign cnt_ext = 33'(cnt_next);
  assign count_o = item_i.last_byte ? '0 : cnt_next;
  assign emit_o  = emit;

  always_comb begin
    result_o.code_point    = cp;
    result_o.seq_len       = len;
    result_o.status        = st;
    result_o.printable     = pr;
    result_o.end_of_string = item_i.last_byte;
    result_o.char_count    = (cnt_ext > 33'h0FFFF) ? {CharCountBits{1'b1}}
                                                   : cnt_ext[CharCountBits-1:0];
  end

endmodule

// ===== src/utf8_stream_validator_unit.sv =====
// Top level of the UTF-8 stream validator: input register, decode and result register.
`timescale 1ns / 1ps
// The block takes one byte of a string per cycle while the input is not stalled, and checks
// and decodes it as UTF-8. An accepted byte sits in an input register; once the result
// register is free, the decode logic updates the small sequence state and, when the byte
// completes a sequence, hits an error or ends the string, writes one transaction into the
// result register. Throughput is one byte per cycle while no result is stalled, set by the
// single decode stage between the two registers; a stalled result holds the input register
// and so stalls the input. Bytes that only extend an open sequence give no result. Every
// final byte gives exactly one result, and the string state is cleared after it.
module utf8_stream_validator_unit #(
  parameter int unsigned COUNT_BITS = utf8sv_pkg::CountBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  utf8sv_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output utf8sv_pkg::out_item_t out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import utf8sv_pkg::*;

  cfg_t                  cfg;
  logic                  in_valid_q;
  in_item_t              in_item_q;
  logic                  out_valid_q;
  out_item_t             out_item_q;
  seq_state_t            seq_q;
  seq_state_t            seq_d;
  logic [COUNT_BITS-1:0] count_q;
  logic [COUNT_BITS-1:0] count_d;
  logic                  emit;
  out_item_t             result;
  logic                  out_free;
  logic                  proc;
  logic                  in_ready;

  utf8sv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  utf8sv_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .seq_i    (seq_q),
    .count_i  (count_q),
    .seq_o    (seq_d),
    .count_o  (count_d),
    .emit_o   (emit),
    .result_o (result)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_ready   = !in_valid_q || out_free;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seq_q       <= '0;
      count_q     <= '0;
    end else begin
      if (in_valid_i && in_ready) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (proc) begin
        seq_q   <= seq_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready) begin
      in_item_q <= in_data_i;
    end
    if (proc && emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

`ifndef SYNTHESIS
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_item_q.last_byte) |-> emit)
    else $error("final byte produced no result");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_OK) |->
      (out_data_o.seq_len != 3'd0 && out_data_o.seq_len <= 3'd4))
    else $error("ok result with impossible sequence length");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && emit && result.status != ST_OK && !in_item_q.last_byte) |=> seq_q.failed_flag)
    else $error("error did not set the failed flag");

  a_printable_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.printable) |-> (out_data_o.status == ST_OK))
    else $error("printable flag on an error result");
`endif

endmodule

// ===== dv/utf8_stream_validator_unit_tb.sv =====
// Self-checking testbench for the UTF-8 stream validator: directed and random strings.
`timescale 1ns / 1ps
module utf8_stream_validator_unit_tb;
  import utf8sv_pkg::*;

  localparam int unsigned CycleLimit = 6000000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  in_item_t in_data = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  utf8_stream_validator_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  in_item_t pending_bytes[$];
  out_item_t expected_results[$];
  logic [7:0] str_bytes[$];

  logic cfg_allow_nl = 1'b1;
  logic cfg_nul_err = 1'b1;

  logic [2:0] seq_expected_len = '0;
  logic [2:0] seq_bytes_seen = '0;
  logic [30:0] seq_accum = '0;
  logic seq_failed = 1'b0;
  logic [15:0] seq_count = '0;

  bit quiet_phase = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned strings_built = 0;
  int unsigned reg_writes = 0;
  logic [7:0] status_seen = '0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("utf8_stream_validator_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
  endtask

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if (b[7] == 1'b0) return 3'd1;
    if (b[7:5] == 3'b110) return 3'd2;
    if (b[7:4] == 4'b1110) return 3'd3;
    if (b[7:3] == 5'b11110) return 3'd4;
    if (b[7:2] == 6'b111110) return 3'd5;
    if (b[7:1] == 7'b1111110) return 3'd6;
    return 3'd0;
  endfunction

  function automatic logic [2:0] shortest_len(input logic [30:0] v);
    if (v < 31'h80) return 3'd1;
    if (v < 31'h800) return 3'd2;
    if (v < 31'h10000) return 3'd3;
    if (v < 31'h200000) return 3'd4;
    if (v < 31'h4000000) return 3'd5;
    return 3'd6;
  endfunction

  function automatic logic scalar_ok(input logic [30:0] v);
    if (v >= 31'h110000) return 1'b0;
    if ((v & 31'h7FFFF800) == 31'hD800) return 1'b0;
    if (v >= 31'hFDD0 && v <= 31'hFDEF) return 1'b0;
    if (v[15:1] == 15'h7FFF) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic printable_cp(input logic [30:0] v);
    if (v < 31'h20 && v != 31'h09 && v != 31'h0A) return 1'b0;
    if (v >= 31'h7F && v <= 31'h9F) return 1'b0;
    if (v == 31'h0A && !cfg_allow_nl) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_byte(input in_item_t it);
    logic emit;
    logic [30:0] cp;
    logic [2:0] len;
    logic [2:0] st;
    logic pr;
    logic [2:0] n;
    out_item_t r;
    emit = 1'b0;
    cp = '0;
    len = '0;
    st = ST_OK;
    pr = 1'b0;
    if (seq_failed) begin
      if (it.last_byte) begin
        emit = 1'b1;
        st = ST_FAILED;
      end
    end else if (seq_expected_len == 3'd0) begin
      n = lead_len(it.data_byte);
      if (it.data_byte == 8'h00 && cfg_nul_err) begin
        emit = 1'b1;
        st = ST_NUL;
        len = 3'd1;
      end else if (n == 3'd0) begin
        emit = 1'b1;
        st = ST_BAD_LEAD;
      end else if (n == 3'd1) begin
        emit = 1'b1;
        cp = {23'd0, it.data_byte};
        len = 3'd1;
        pr = printable_cp(cp);
      end else begin
        seq_expected_len = n;
        seq_bytes_seen = 3'd1;
        seq_accum = {23'd0, it.data_byte & (8'h7F >> n)};
        if (it.last_byte) begin
          emit = 1'b1;
          st = ST_TRUNC;
          len = n;
        end
      end
    end else begin
      len = seq_expected_len;
      if (it.data_byte[7:6] != 2'b10) begin
        emit = 1'b1;
        st = ST_BAD_CONT;
      end else begin
        seq_accum = {seq_accum[24:0], it.data_byte[5:0]};
        seq_bytes_seen = seq_bytes_seen + 3'd1;
        if (seq_bytes_seen >= seq_expected_len) begin
          emit = 1'b1;
          if (shortest_len(seq_accum) != seq_expected_len) st = ST_OVERLONG;
          else if (!scalar_ok(seq_accum)) st = ST_NOT_SCALAR;
          else begin
            cp = seq_accum;
            pr = printable_cp(cp);
          end
        end else if (it.last_byte) begin
          emit = 1'b1;
          st = ST_TRUNC;
        end
      end
      if (emit) begin
        seq_expected_len = '0;
        seq_bytes_seen = '0;
        seq_accum = '0;
      end
    end
    if (!emit) return;
    if (st == ST_OK) begin
      if (seq_count != 16'hFFFF) seq_count = seq_count + 16'd1;
    end else begin
      seq_failed = 1'b1;
      cp = '0;
      pr = 1'b0;
      if (st == ST_FAILED || st == ST_BAD_LEAD) len = '0;
    end
    r.code_point = cp;
    r.seq_len = len;
    r.status = st;
    r.printable = pr;
    r.end_of_string = it.last_byte;
    r.char_count = seq_count;
    expected_results.push_back(r);
    if (it.last_byte) begin
      seq_expected_len = '0;
      seq_bytes_seen = '0;
      seq_accum = '0;
      seq_failed = 1'b0;
      seq_count = '0;
    end
  endtask

  // Byte driver: holds a stalled transaction, inserts random gaps outside the quiet phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall_o) begin
        predict_byte(in_data);
        bytes_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          in_data <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall) begin
        status_seen[out_data_o.status] = 1'b1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(out_data_o.status), '0);
        end else begin
          out_item_t want;
          want = expected_results.pop_front();
          results_checked++;
          if (out_data_o.code_point !== want.code_point)
            report_mismatch("code_point", 32'(out_data_o.code_point), 32'(want.code_point));
          if (out_data_o.seq_len !== want.seq_len)
            report_mismatch("seq_len", 32'(out_data_o.seq_len), 32'(want.seq_len));
          if (out_data_o.status !== want.status)
            report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
          if (out_data_o.printable !== want.printable)
            report_mismatch("printable", 32'(out_data_o.printable), 32'(want.printable));
          if (out_data_o.end_of_string !== want.end_of_string)
            report_mismatch("end_of_string", 32'(out_data_o.end_of_string),
                            32'(want.end_of_string));
          if (out_data_o.char_count !== want.char_count)
            report_mismatch("char_count", 32'(out_data_o.char_count), 32'(want.char_count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.data_byte = b;
    it.last_byte = last;
    pending_bytes.push_back(it);
  endtask

  task automatic flush_string();
    for (int i = 0; i < str_bytes.size(); i++)
      push_byte(str_bytes[i], i == str_bytes.size() - 1);
    str_bytes.delete();
    strings_built++;
  endtask

  function automatic logic [31:0] seq_limit(input int n);
    case (n)
      1: return 32'h80;
      2: return 32'h800;
      3: return 32'h10000;
      4: return 32'h200000;
      default: return 32'h4000000;
    endcase
  endfunction

  function automatic logic [31:0] pick_valid(input int n);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = (n == 1) ? 32'h0 : seq_limit(n - 1);
    hi = (n == 4) ? 32'h10FFFF : seq_limit(n) - 1;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [7:0] seq_byte(input logic [31:0] v, input int n, input int k);
    logic [31:0] w;
    if (n == 1) return v[7:0] & 8'h7F;
    if (k == 0) w = ((32'hFF << (8 - n)) & 32'hFF) | ((v >> (6 * (n - 1))) & (32'h7F >> n));
    else w = 32'h80 | ((v >> (6 * (n - 1 - k))) & 32'h3F);
    return w[7:0];
  endfunction

  task automatic add_char(input int kind);
    logic [31:0] v;
    int n;
    int keep;
    keep = 0;
    if (kind < 40) begin
      v = $urandom_range(127, 1);
      n = 1;
    end else if (kind < 55) begin
      n = 2;
      v = pick_valid(n);
    end else if (kind < 67) begin
      n = 3;
      v = pick_valid(n);
    end else if (kind < 77) begin
      n = 4;
      v = pick_valid(n);
    end else if (kind < 80) begin
      case ($urandom_range(3, 0))
        0: v = 32'hD800 + $urandom_range(32'h7FF, 0);
        1: v = 32'hFDD0 + $urandom_range(32'h1F, 0);
        2: v = ($urandom_range(16, 0) << 16) | 32'hFFFE | $urandom_range(1, 0);
        default: v = $urandom_range(32'h1FFFFF, 32'h110000);
      endcase
      n = (v < 32'h10000) ? 3 : 4;
    end else if (kind < 83) begin
      n = $urandom_range(6, 2);
      v = $urandom_range(seq_limit(n - 1) - 1, 0);
    end else if (kind < 85) begin
      n = $urandom_range(6, 5);
      v = (n == 5) ? ($urandom & 32'h3FFFFFF) : ($urandom & 32'h7FFFFFFF);
    end else if (kind < 88) begin
      v = 32'h0;
      n = 1;
    end else if (kind < 92) begin
      str_bytes.push_back(8'($urandom_range(255, 0)));
      return;
    end else if (kind < 96) begin
      n = $urandom_range(4, 2);
      v = pick_valid(n);
      keep = $urandom_range(n - 1, 1);
    end else begin
      n = 1;
      case ($urandom_range(3, 0))
        0: v = 32'h0A;
        1: v = 32'h09;
        2: v = 32'h7F;
        default: begin
          v = $urandom_range(32'h9F, 32'h80);
          n = 2;
        end
      endcase
    end
    if (keep == 0) keep = n;
    for (int k = 0; k < keep; k++) str_bytes.push_back(seq_byte(v, n, k));
  endtask

  // Most strings are well formed; the rest mix in malformed sequences and noise.
  task automatic build_random_strings(input int byte_budget);
    int added;
    int nchars;
    bit clean;
    int kind;
    added = 0;
    while (added < byte_budget) begin
      nchars = $urandom_range(10, 1);
      clean = ($urandom_range(9, 0) < 7);
      for (int c = 0; c < nchars; c++) begin
        kind = $urandom_range(99, 0);
        if (clean && kind >= 77 && kind < 96) kind = $urandom_range(76, 0);
        add_char(kind);
      end
      added += str_bytes.size();
      flush_string();
    end
  endtask

  task automatic wait_all_done();
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic reg_idx, input logic val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= {31'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_LF_PRINTABLE) cfg_allow_nl = val;
    else cfg_nul_err = val;
    reg_writes++;
  endtask

  task automatic set_config(input logic allow_nl, input logic nul_err);
    wait_all_done();
    write_reg(REG_LF_PRINTABLE, allow_nl);
    write_reg(REG_NUL_IS_ERROR, nul_err);
    @(negedge clk_i);
  endtask

  task automatic add_directed();
    push_byte(8'h00, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h0A, 1'b1);
    push_byte(8'hC2, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hF4, 1'b0);
    push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBD, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hC0, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'hED, 1'b0);
    push_byte(8'hA0, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBE, 1'b1);
    push_byte(8'hF4, 1'b0);
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'hE2, 1'b1);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h41, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h41, 1'b1);
    push_byte(8'hF8, 1'b0);
    push_byte(8'h88, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_directed();
    build_random_strings(300);
    wait_all_done();
    build_random_strings(100);

    set_config(1'b0, 1'b0);
    build_random_strings(350);

    set_config(1'b1, 1'b0);
    build_random_strings(250);

    set_config(1'b0, 1'b1);
    build_random_strings(250);

    set_config(1'b1, 1'b1);
    quiet_phase = 1'b1;
    build_random_strings(250);

    wait_all_done();
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", '0, 32'(expected_results.size()));

    $display("run covered %0d bytes in %0d strings, %0d results checked, %0d register writes",
             bytes_sent, strings_built, results_checked, reg_writes);
    $display("status codes seen %b, under all four register settings", status_seen);
    if (error_count == 0) begin
      $display("utf8_stream_validator_unit_tb: done, clean");
    end else begin
      $display("utf8_stream_validator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
